FILE: rtl/nvds_pkg.sv
// Shared types and constants for the nearest valid depth search block.
// Used by the top level, the window scanner and the checker; no dependencies.
package nvds_pkg;

    localparam int DEFAULT_ROWS = 424;
    localparam int DEFAULT_COLS = 512;

    // Coordinate width covers a clamped center (up to 511) plus a 9-bit half width.
    localparam int CW      = 11;
    localparam int PIX_W   = 16;
    localparam int PADDR_W = 3;

    localparam logic [PIX_W-1:0] THR_RESET = 16'd1000;

    localparam logic REG_THRESHOLD = 1'b0;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic [CW-1:0] r0;
        logic [CW-1:0] r1;
        logic [CW-1:0] c0;
        logic [CW-1:0] c1;
    } t_window;

    typedef struct packed {
        logic             found;
        logic [PIX_W-1:0] value;
    } t_scan_res;

endpackage

FILE: rtl/nvds_scan.sv
// Depth image memory and the ring-by-ring window scanner.
// Depends on nvds_pkg for the window and result types.
module nvds_scan
    import nvds_pkg::*;
#(
    parameter int IMAGE_ROWS = DEFAULT_ROWS,
    parameter int IMAGE_COLS = DEFAULT_COLS,
    parameter int AW         = $clog2(IMAGE_ROWS * IMAGE_COLS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [PIX_W-1:0] i_thr,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [PIX_W-1:0] i_wr_data,
    input  logic             i_qry_vld,
    input  t_window          i_win,
    output logic             o_busy,
    output logic             o_res_vld,
    output t_scan_res        o_res,
    input  logic             i_res_rdy
);

    localparam int DEPTH = IMAGE_ROWS * IMAGE_COLS;
    localparam logic [CW-1:0] ROW_LAST = CW'(IMAGE_ROWS - 1);
    localparam logic [CW-1:0] COL_LAST = CW'(IMAGE_COLS - 1);
    localparam logic [AW-1:0] ROW_STEP = AW'(IMAGE_COLS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_SCAN,
        S_GROW,
        S_DONE
    } t_state;

    logic [PIX_W-1:0] mem [DEPTH];

    t_state           r_state;
    t_window          r_win;
    t_window          r_prev;
    logic             r_have_prev;
    logic [CW-1:0]    r_i;
    logic [CW-1:0]    r_j;
    logic             r_seg;
    logic [AW-1:0]    r_base;
    logic [AW-1:0]    r_base0;
    logic             r_rd_vld;
    logic [PIX_W-1:0] r_rd_data;
    t_scan_res        r_res;

    t_window          n_win;
    logic [AW-1:0]    n_base0;
    logic             row_inner;
    logic             issue;
    logic             row_end;
    logic             jump;
    logic             ring_end;
    logic             hit;
    logic             full;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;

    assign row_inner = r_have_prev && (r_i >= r_prev.r0) && (r_i <= r_prev.r1);

    always_comb begin
        issue   = 1'b0;
        row_end = 1'b0;
        jump    = 1'b0;
        if (!row_inner) begin
            issue   = 1'b1;
            row_end = (r_j == r_win.c1);
        end else if (!r_seg) begin
            if (r_win.c0 == r_prev.c0) begin
                jump = 1'b1;
            end else begin
                issue = 1'b1;
                jump  = (r_j == r_prev.c0 - CW'(1));
            end
        end else begin
            if (r_prev.c1 == r_win.c1) begin
                row_end = 1'b1;
            end else begin
                issue   = 1'b1;
                row_end = (r_j == r_win.c1);
            end
        end
    end

    assign ring_end = row_end && (r_i == r_win.r1);
    assign hit      = r_rd_vld && (r_rd_data > i_thr);
    assign full     = (r_win.r0 == '0) && (r_win.r1 == ROW_LAST)
                   && (r_win.c0 == '0) && (r_win.c1 == COL_LAST);
    assign rd_en    = (r_state == S_SCAN) && issue && !hit;
    assign rd_addr  = r_base + AW'(r_j);

    always_comb begin
        n_win.r0 = (r_win.r0 == '0) ? '0 : r_win.r0 - CW'(1);
        n_win.r1 = (r_win.r1 == ROW_LAST) ? ROW_LAST : r_win.r1 + CW'(1);
        n_win.c0 = (r_win.c0 == '0) ? '0 : r_win.c0 - CW'(1);
        n_win.c1 = (r_win.c1 == COL_LAST) ? COL_LAST : r_win.c1 + CW'(1);
        n_base0  = (r_win.r0 == '0) ? r_base0 : r_base0 - ROW_STEP;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_vld    <= 1'b0;
            r_have_prev <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
            unique case (r_state)
                S_IDLE: begin
                    if (i_qry_vld) begin
                        r_win       <= i_win;
                        r_have_prev <= 1'b0;
                        r_state     <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_base  <= AW'(r_win.r0) * ROW_STEP;
                    r_base0 <= AW'(r_win.r0) * ROW_STEP;
                    r_i     <= r_win.r0;
                    r_j     <= r_win.c0;
                    r_seg   <= 1'b0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (hit) begin
                        r_res   <= '{found: 1'b1, value: r_rd_data};
                        r_state <= S_DONE;
                    end else if (ring_end) begin
                        r_state <= S_GROW;
                    end else if (row_end) begin
                        r_i    <= r_i + CW'(1);
                        r_base <= r_base + ROW_STEP;
                        r_j    <= r_win.c0;
                        r_seg  <= 1'b0;
                    end else if (jump) begin
                        r_seg <= 1'b1;
                        r_j   <= r_prev.c1 + CW'(1);
                    end else if (issue) begin
                        r_j <= r_j + CW'(1);
                    end
                end
                S_GROW: begin
                    if (hit) begin
                        r_res   <= '{found: 1'b1, value: r_rd_data};
                        r_state <= S_DONE;
                    end else if (full) begin
                        r_res   <= '{found: 1'b0, value: '0};
                        r_state <= S_DONE;
                    end else begin
                        r_prev      <= r_win;
                        r_have_prev <= 1'b1;
                        r_win       <= n_win;
                        r_i         <= n_win.r0;
                        r_j         <= n_win.c0;
                        r_seg       <= 1'b0;
                        r_base      <= n_base0;
                        r_base0     <= n_base0;
                        r_state     <= S_SCAN;
                    end
                end
                S_DONE: begin
                    if (i_res_rdy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_res_vld = (r_state == S_DONE);
    assign o_res     = r_res;

endmodule

FILE: rtl/nearest_valid_depth_search.sv
// Top level of the nearest valid depth search block: stream ports, register port,
// request decode and the result register. Depends on nvds_pkg and nvds_scan.
//
//   channel   direction  width      contents
//   s_axis    in         48 + 1     pixel write or query request
//   m_axis    out        16 + 1     query result
//   APB       in/out     32         valid_threshold at byte address 0
//
// A pixel write is staged in the write registers before it lands in the image memory.
// A query passes a setup state, then reads the pixels of each ring one by one, takes a step for each empty
// side strip of a row inside the previous window, and takes a growth step at the end of each ring.
// A hit is seen the cycle after its read; the result then passes the scanner's result register and the output register.
// Reset is synchronous; the image memory keeps no reset and holds garbage until written.
// Requests are refused while a query runs; a finished result waits in its own register,
// so the next request is taken while the result is still stalled downstream.
module nearest_valid_depth_search
    import nvds_pkg::*;
#(
    parameter int IMAGE_ROWS = DEFAULT_ROWS,
    parameter int IMAGE_COLS = DEFAULT_COLS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [47:0]        s_axis_tdata,  // row[8:0], col[17:9], depth_value[33:18],
                                              // half_width[42:34], zero fill
    input  logic               s_axis_tuser,  // opcode
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [PIX_W-1:0]   m_axis_tdata,  // found_value[15:0]
    output logic               m_axis_tuser,  // found
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = $clog2(IMAGE_ROWS * IMAGE_COLS);
    localparam logic [CW-1:0] ROW_LAST = CW'(IMAGE_ROWS - 1);
    localparam logic [CW-1:0] COL_LAST = CW'(IMAGE_COLS - 1);

    logic [PIX_W-1:0] r_thr;
    logic             r_wr_en;
    logic [AW-1:0]    r_wr_addr;
    logic [PIX_W-1:0] r_wr_data;
    logic             r_out_vld;
    t_scan_res        r_out;

    logic [8:0]       in_row;
    logic [8:0]       in_col;
    logic [PIX_W-1:0] in_depth;
    logic [8:0]       in_hw;
    logic [CW-1:0]    row_w;
    logic [CW-1:0]    col_w;
    logic [CW-1:0]    hw_w;
    logic [CW-1:0]    cr;
    logic [CW-1:0]    cc;
    t_window          qry_win;
    logic             accept;
    logic             qry_vld;
    logic             in_range;
    logic             busy;
    logic             res_vld;
    logic             res_rdy;
    t_scan_res        res;

    assign in_row   = s_axis_tdata[8:0];
    assign in_col   = s_axis_tdata[17:9];
    assign in_depth = s_axis_tdata[33:18];
    assign in_hw    = s_axis_tdata[42:34];
    assign row_w    = CW'(in_row);
    assign col_w    = CW'(in_col);
    assign hw_w     = CW'(in_hw);

    assign s_axis_tready = !busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign qry_vld       = accept && (s_axis_tuser == OP_QUERY);
    assign in_range      = (row_w <= ROW_LAST) && (col_w <= COL_LAST);

    always_comb begin
        cr         = (row_w > ROW_LAST) ? ROW_LAST : row_w;
        cc         = (col_w > COL_LAST) ? COL_LAST : col_w;
        qry_win.r0 = (cr >= hw_w) ? cr - hw_w : '0;
        qry_win.r1 = (cr + hw_w > ROW_LAST) ? ROW_LAST : cr + hw_w;
        qry_win.c0 = (cc >= hw_w) ? cc - hw_w : '0;
        qry_win.c1 = (cc + hw_w > COL_LAST) ? COL_LAST : cc + hw_w;
    end

    // Register port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_THRESHOLD) ? {16'b0, r_thr} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_THRESHOLD)) begin
            r_thr <= pwdata[PIX_W-1:0];
        end
    end

    // Pixel writes are staged one cycle so the address multiply has its own stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_en <= 1'b0;
        end else begin
            r_wr_en <= accept && (s_axis_tuser == OP_WRITE) && in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr <= AW'(in_row) * AW'(IMAGE_COLS) + AW'(in_col);
        r_wr_data <= in_depth;
    end

    nvds_scan #(
        .IMAGE_ROWS (IMAGE_ROWS),
        .IMAGE_COLS (IMAGE_COLS),
        .AW         (AW)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_thr     (r_thr),
        .i_wr_en   (r_wr_en),
        .i_wr_addr (r_wr_addr),
        .i_wr_data (r_wr_data),
        .i_qry_vld (qry_vld),
        .i_win     (qry_win),
        .o_busy    (busy),
        .o_res_vld (res_vld),
        .o_res     (res),
        .i_res_rdy (res_rdy)
    );

    // Result register.
    assign res_rdy = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_vld && res_rdy) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_vld && res_rdy) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out.value;
    assign m_axis_tuser  = r_out.found;

endmodule

FILE: rtl/nvds_checker.sv
// Port-level checks for the nearest valid depth search block, bound to its top level.
// Depends on nvds_pkg for the data width.
module nvds_checker
    import nvds_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_tvalid,
    input logic             i_s_tready,
    input logic             i_s_tuser,
    input logic             i_m_tvalid,
    input logic             i_m_tready,
    input logic [PIX_W-1:0] i_m_tdata,
    input logic             i_m_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("stalled result changed");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tuser |-> i_m_tdata == '0)
        else $error("not-found result carries a nonzero value");

    a_hit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser |-> i_m_tdata != '0)
        else $error("found result carries zero, which can never exceed the threshold");

    a_query_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready && (i_s_tuser == OP_QUERY) |=> !i_s_tready)
        else $error("request taken while a query is running");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid right after reset");

endmodule

bind nearest_valid_depth_search nvds_checker u_nvds_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_s_tuser  (s_axis_tuser),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);
